/* rtl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types and constants of the UTF-8 to UTF-16 transcoder
// Holds the job descriptor that the front end hands to the back end and the
// code values that both ends use.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;

  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // One job per byte that produces output: rep_cnt replacement units first,
  // then optionally the code point cp (one unit, or a surrogate pair).
  typedef struct packed {
    logic [2:0]  rep_cnt;
    logic        has_cp;
    logic [20:0] cp;
    logic        fin;
  } job_t;

endpackage

/* rtl/u8u16_front.sv */
// ----------------------------------------------------------------------------
// u8u16_front: byte decoder front end
// Tracks the open UTF-8 sequence, validates each byte and turns it into a
// job descriptor for the back end.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  input  logic               in_final,
  output logic               job_push,
  output u8u16_pkg::job_t    job
);
  import u8u16_pkg::*;

  logic [7:0]  lead;
  logic [1:0]  needed;
  logic [1:0]  taken;
  logic [20:0] partial;

  logic [7:0]  lead_next;
  logic [1:0]  needed_next;
  logic [1:0]  taken_next;
  logic [20:0] partial_next;

  logic        st_open;
  logic [1:0]  st_needed;
  logic [20:0] st_partial;
  logic        st_has_cp;
  logic [20:0] st_cp;
  logic        cont_ok;
  logic [1:0]  taken_inc;
  logic [2:0]  rep;

  // Decode of the byte as a fresh lead.
  always_comb begin
    st_open    = 1'b0;
    st_needed  = 2'd0;
    st_partial = '0;
    st_has_cp  = 1'b0;
    st_cp      = '0;
    if (in_byte[7] == 1'b0) begin
      st_has_cp = 1'b1;
      st_cp     = {13'd0, in_byte};
    end else if (in_byte inside {[8'hC2:8'hDF]}) begin
      st_open    = 1'b1;
      st_needed  = 2'd1;
      st_partial = {16'd0, in_byte[4:0]};
    end else if (in_byte inside {[8'hE0:8'hEF]}) begin
      st_open    = 1'b1;
      st_needed  = 2'd2;
      st_partial = {17'd0, in_byte[3:0]};
    end else if (in_byte inside {[8'hF0:8'hF4]}) begin
      st_open    = 1'b1;
      st_needed  = 2'd3;
      st_partial = {18'd0, in_byte[2:0]};
    end else begin
      st_has_cp = 1'b1;
      st_cp     = {5'd0, REPL_UNIT};
    end
  end

  // The second byte of some leads has a narrower range.
  always_comb begin
    cont_ok = (in_byte[7:6] == 2'b10);
    if (taken == 2'd0) begin
      if (lead == LEAD_E0 && in_byte < 8'hA0) cont_ok = 1'b0;
      if (lead == LEAD_ED && in_byte >= 8'hA0) cont_ok = 1'b0;
      if (lead == LEAD_F0 && in_byte < 8'h90) cont_ok = 1'b0;
      if (lead == LEAD_F4 && in_byte > 8'h8F) cont_ok = 1'b0;
    end
  end

  assign taken_inc = taken + 2'd1;

  always_comb begin
    lead_next    = lead;
    needed_next  = needed;
    taken_next   = taken;
    partial_next = partial;
    rep          = 3'd0;
    job.has_cp   = 1'b0;
    job.cp       = '0;
    if (needed == 2'd0) begin
      if (st_open) begin
        lead_next    = in_byte;
        needed_next  = st_needed;
        taken_next   = 2'd0;
        partial_next = st_partial;
      end
      job.has_cp = st_has_cp;
      job.cp     = st_cp;
    end else if (cont_ok) begin
      partial_next = {partial[14:0], in_byte[5:0]};
      taken_next   = taken_inc;
      if (taken_inc == needed) begin
        job.has_cp   = 1'b1;
        job.cp       = {partial[14:0], in_byte[5:0]};
        lead_next    = 8'd0;
        needed_next  = 2'd0;
        taken_next   = 2'd0;
        partial_next = '0;
      end
    end else begin
      // Broken sequence: lead and buffered bytes each give a replacement,
      // then the byte is decoded as a new lead.
      rep          = 3'd1 + {1'b0, taken};
      lead_next    = st_open ? in_byte : 8'd0;
      needed_next  = st_open ? st_needed : 2'd0;
      taken_next   = 2'd0;
      partial_next = st_open ? st_partial : '0;
      job.has_cp   = st_has_cp;
      job.cp       = st_cp;
    end
    // String end flushes whatever sequence is still open.
    if (in_final && needed_next != 2'd0) begin
      rep          = rep + 3'd1 + {1'b0, taken_next};
      lead_next    = 8'd0;
      needed_next  = 2'd0;
      taken_next   = 2'd0;
      partial_next = '0;
    end
    job.rep_cnt = rep;
    job.fin     = in_final;
  end

  assign job_push = accept && (rep != 3'd0 || job.has_cp);

  always_ff @(posedge clk) begin
    if (rst) begin
      lead    <= 8'd0;
      needed  <= 2'd0;
      taken   <= 2'd0;
      partial <= '0;
    end else if (accept) begin
      lead    <= lead_next;
      needed  <= needed_next;
      taken   <= taken_next;
      partial <= partial_next;
    end
  end

endmodule

/* rtl/u8u16_queue.sv */
// ----------------------------------------------------------------------------
// u8u16_queue: job queue between front end and back end
// A small register queue that lets the two ends stall independently.
// ----------------------------------------------------------------------------
module u8u16_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  u8u16_pkg::job_t    push_job,
  input  logic               pop,
  output u8u16_pkg::job_t    head,
  output logic               not_empty,
  output logic               full
);
  import u8u16_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/u8u16_back.sv */
// ----------------------------------------------------------------------------
// u8u16_back: code unit emitter back end
// Expands each job into replacement units, a BMP unit or a surrogate pair,
// one unit per cycle into the output register, unless the output stalls.
// ----------------------------------------------------------------------------
module u8u16_back (
  input  logic               clk,
  input  logic               rst,
  input  u8u16_pkg::job_t    head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        code_unit,
  output logic               run_end,
  output logic               text_end
);
  import u8u16_pkg::*;

  logic [1:0]  idx;
  logic [2:0]  total;
  logic        is_pair;
  logic [20:0] offs;
  logic        last;
  logic        load;
  logic        emit;
  logic [15:0] unit;

  assign is_pair = head.cp > BMP_MAX;
  assign offs    = head.cp - SUPP_BASE;
  assign total   = head.rep_cnt + (head.has_cp ? (is_pair ? 3'd2 : 3'd1) : 3'd0);
  assign last    = ({1'b0, idx} + 3'd1) == total;
  assign load    = !out_valid || out_ready;
  assign emit    = head_valid && load;
  assign pop     = emit && last;

  always_comb begin
    if ({1'b0, idx} < head.rep_cnt) begin
      unit = REPL_UNIT;
    end else if (is_pair) begin
      unit = ({1'b0, idx} == head.rep_cnt) ? HI_SURR_BASE + {6'd0, offs[19:10]}
                                           : LO_SURR_BASE + {6'd0, offs[9:0]};
    end else begin
      unit = head.cp[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (emit) idx <= last ? 2'd0 : idx + 2'd1;
      if (load) out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code_unit <= unit;
      run_end   <= last;
      text_end  <= last && head.fin;
    end
  end

endmodule

/* rtl/utf8_to_utf16_transcoder_core.sv */
// A byte that yields output is written as a job into the queue; the back end then
// registers its first code unit into the output register when it reaches that job.
// Throughput: one byte per cycle while each byte yields at most one code unit and
// the output is not stalled; a byte with several units holds the single output port.
// The job queue holds four jobs, so input stalls only once it fills.
// Reset (rst, synchronous, active high) closes any open sequence and empties the queue.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core: UTF-8 to UTF-16 transcoder
// Validates a UTF-8 byte stream and emits UTF-16 code units, with U+FFFD
// replacements for malformed or truncated sequences.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_final,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        run_end,
  output logic        text_end
);
  import u8u16_pkg::*;

  // The front end decodes one byte per input transaction. Every byte that
  // produces output becomes one job: a count of replacement units followed
  // by an optional code point. Bytes that only open or extend a sequence
  // produce no job at all.
  job_t job;
  logic job_push;
  logic accept;

  // The queue decouples the decoder from the emitter. Its ready only
  // depends on its fill level, never on the output handshake.
  job_t head;
  logic head_valid;
  logic q_full;
  logic pop;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  u8u16_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_final (in_final),
    .job_push (job_push),
    .job      (job)
  );

  u8u16_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (job),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid),
    .full      (q_full)
  );

  // The back end walks through the units of the head job, one per cycle unless the
  // output stalls, and releases the job when its last unit enters the output register.
  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_unit  (code_unit),
    .run_end    (run_end),
    .text_end   (text_end)
  );

endmodule

/* rtl/u8u16_checker.sv */
// ----------------------------------------------------------------------------
// u8u16_checker: port-level checks for the transcoder
// Watches the top-level ports and flags ordering and handshake slips.
// ----------------------------------------------------------------------------
module u8u16_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_final,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] code_unit,
  input  logic        run_end,
  input  logic        text_end
);

  // Nothing is offered on the output right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // A stalled input transaction keeps its byte and flag.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(in_final))
    else $error("stalled input transaction changed");

  // A stalled output transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_unit) && $stable(run_end)
      && $stable(text_end))
    else $error("stalled output transaction changed");

  // The end of the string is always also the end of a byte's run.
  a_text_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_end |-> run_end)
    else $error("text_end without run_end");

  // A high surrogate is never the last unit of a byte.
  a_hi_surr: assert property (@(posedge clk) disable iff (rst)
    out_valid && code_unit >= 16'hD800 && code_unit <= 16'hDBFF |-> !run_end)
    else $error("high surrogate ends a run");

endmodule

bind utf8_to_utf16_transcoder_core u8u16_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_byte   (in_byte),
  .in_final  (in_final),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .code_unit (code_unit),
  .run_end   (run_end),
  .text_end  (text_end)
);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the UTF-8 to UTF-16 transcoder core
// A clocked driver offers bytes from a prefilled queue and a clocked monitor
// compares every emitted code unit with a local transcoder model. Both sides
// idle at random rates, and a long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb;
  import u8u16_pkg::*;

  // One byte of UTF-8 text with its end-of-string mark.
  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } text_byte_t;

  // One UTF-16 code unit as the block should emit it.
  typedef struct packed {
    logic [15:0] unit;
    logic        run_end;
    logic        text_end;
  } utf16_unit_t;

  localparam int unsigned RANDOM_BYTES = 400;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned DRAIN_CYCLES = 12;
  // Accepted-byte counts at which the idling pattern changes.
  localparam int unsigned PHASE1_AT    = 140;
  localparam int unsigned PHASE2_AT    = 280;
  localparam int unsigned HOLD_AT      = 300;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte   = 8'h00;
  logic        in_final  = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] code_unit;
  logic        run_end;
  logic        text_end;

  utf8_to_utf16_transcoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_final  (in_final),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_unit (code_unit),
    .run_end   (run_end),
    .text_end  (text_end)
  );

  // Bytes still to be offered, and code units still to be seen.
  text_byte_t  text_pending[$];
  utf16_unit_t units_due[$];

  int unsigned bytes_taken_cnt = 0;
  int unsigned mismatch_cnt    = 0;
  int unsigned cycle_cnt       = 0;
  int unsigned hold_left       = 0;
  bit          hold_done       = 1'b0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // --------------------------------------------------------------------------
  // Transcoder model. It keeps its own copy of the open-sequence state and
  // turns each accepted byte into the list of code units it must cause.
  // --------------------------------------------------------------------------
  logic [7:0]  seq_lead  = 8'h00;
  logic [1:0]  seq_need  = 2'd0;
  logic [1:0]  seq_got   = 2'd0;
  logic [20:0] seq_point = 21'd0;
  logic [15:0] step_units[$];

  function automatic void add_unit(logic [15:0] unit);
    step_units = {step_units, unit};
  endfunction

  function automatic void emit_point(logic [20:0] cp);
    logic [19:0] off;
    if (cp <= BMP_MAX) begin
      add_unit(cp[15:0]);
    end else begin
      // Supplementary planes go out as a high and then a low surrogate.
      off = 20'(cp - SUPP_BASE);
      add_unit(HI_SURR_BASE + {6'd0, off[19:10]});
      add_unit(LO_SURR_BASE + {6'd0, off[9:0]});
    end
  endfunction

  function automatic void clear_open_seq();
    seq_lead  = 8'h00;
    seq_need  = 2'd0;
    seq_got   = 2'd0;
    seq_point = 21'd0;
  endfunction

  // A failed or cut-short sequence: one replacement for the lead and one for
  // each continuation byte gathered so far.
  function automatic void drop_open_seq();
    add_unit(REPL_UNIT);
    for (int k = 0; k < int'(seq_got); k++) add_unit(REPL_UNIT);
    clear_open_seq();
  endfunction

  function automatic void open_seq(logic [7:0] b);
    if (b <= 8'h7F) begin
      add_unit({8'h00, b});
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      seq_lead  = b;
      seq_need  = 2'd1;
      seq_point = {16'd0, b[4:0]};
    end else if (b >= LEAD_E0 && b <= 8'hEF) begin
      seq_lead  = b;
      seq_need  = 2'd2;
      seq_point = {17'd0, b[3:0]};
    end else if (b >= LEAD_F0 && b <= LEAD_F4) begin
      seq_lead  = b;
      seq_need  = 2'd3;
      seq_point = {18'd0, b[2:0]};
    end else begin
      add_unit(REPL_UNIT);
    end
  endfunction

  // The first continuation after some leads has a narrower range, which
  // excludes overlong forms, surrogates and points above the last plane.
  function automatic bit cont_fits(logic [7:0] b);
    if (b[7:6] != 2'b10) return 1'b0;
    if (seq_got == 2'd0) begin
      if (seq_lead == LEAD_E0 && b < 8'hA0) return 1'b0;
      if (seq_lead == LEAD_ED && b >= 8'hA0) return 1'b0;
      if (seq_lead == LEAD_F0 && b < 8'h90) return 1'b0;
      if (seq_lead == LEAD_F4 && b > 8'h8F) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void transcode_byte(logic [7:0] b, logic fin);
    utf16_unit_t u;
    step_units.delete();
    if (seq_need == 2'd0) begin
      open_seq(b);
    end else if (cont_fits(b)) begin
      seq_point = {seq_point[14:0], b[5:0]};
      seq_got   = seq_got + 2'd1;
      if (seq_got >= seq_need) begin
        emit_point(seq_point);
        clear_open_seq();
      end
    end else begin
      // The breaking byte is decoded again as a new lead.
      drop_open_seq();
      open_seq(b);
    end
    // End of string flushes whatever sequence is still open.
    if (fin && seq_need != 2'd0) drop_open_seq();
    foreach (step_units[i]) begin
      u.unit     = step_units[i];
      u.run_end  = (i == step_units.size() - 1);
      u.text_end = (i == step_units.size() - 1) && fin;
      units_due = {units_due, u};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic void queue_byte(logic [7:0] b, logic fin);
    text_byte_t t;
    t.b   = b;
    t.fin = fin;
    text_pending = {text_pending, t};
  endfunction

  // Builds one well-formed sequence of random length and content. The E0
  // and ED leads get extra weight because their second byte is narrower.
  function automatic void build_sequence(ref logic [7:0] seq[$]);
    int unsigned len;
    int unsigned pick;
    logic [7:0]  lead;
    seq.delete();
    len = $urandom_range(4, 1);
    case (len)
      1: begin
        seq = {seq, 8'($urandom_range(8'h7F, 8'h00))};
      end
      2: begin
        seq = {seq, 8'($urandom_range(8'hDF, 8'hC2))};
        seq = {seq, 8'($urandom_range(8'hBF, 8'h80))};
      end
      3: begin
        pick = $urandom_range(3, 0);
        lead = (pick == 0) ? LEAD_E0 :
               (pick == 1) ? LEAD_ED : 8'($urandom_range(8'hEF, 8'hE0));
        seq = {seq, lead};
        if (lead == LEAD_E0)      seq = {seq, 8'($urandom_range(8'hBF, 8'hA0))};
        else if (lead == LEAD_ED) seq = {seq, 8'($urandom_range(8'h9F, 8'h80))};
        else                      seq = {seq, 8'($urandom_range(8'hBF, 8'h80))};
        seq = {seq, 8'($urandom_range(8'hBF, 8'h80))};
      end
      default: begin
        lead = 8'($urandom_range(LEAD_F4, LEAD_F0));
        seq = {seq, lead};
        if (lead == LEAD_F0)      seq = {seq, 8'($urandom_range(8'hBF, 8'h90))};
        else if (lead == LEAD_F4) seq = {seq, 8'($urandom_range(8'h8F, 8'h80))};
        else                      seq = {seq, 8'($urandom_range(8'hBF, 8'h80))};
        seq = {seq, 8'($urandom_range(8'hBF, 8'h80))};
        seq = {seq, 8'($urandom_range(8'hBF, 8'h80))};
      end
    endcase
  endfunction

  // A byte that the given lead rejects as its first continuation.
  function automatic logic [7:0] bad_second(logic [7:0] lead);
    case (lead)
      LEAD_E0: return 8'($urandom_range(8'h9F, 8'h80));
      LEAD_ED: return 8'($urandom_range(8'hBF, 8'hA0));
      LEAD_F0: return 8'($urandom_range(8'h8F, 8'h80));
      LEAD_F4: return 8'($urandom_range(8'hBF, 8'h90));
      default: return 8'($urandom_range(8'h7F, 8'h00));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Clock and the idling schedule. The schedule follows the number of bytes
  // accepted so far: sender light and receiver heavy, then the reverse, then
  // no idling at all.
  // --------------------------------------------------------------------------
  initial begin
    forever #10 clk = ~clk;
  end

  always_comb begin
    if (bytes_taken_cnt < PHASE1_AT) begin
      send_idle_pct = 18;
      recv_idle_pct = 47;
    end else if (bytes_taken_cnt < PHASE2_AT) begin
      send_idle_pct = 47;
      recv_idle_pct = 18;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // --------------------------------------------------------------------------
  // Driver. A new transaction is offered only when the input channel is free,
  // i.e. nothing is presented or the presented byte is being accepted at this
  // edge. Otherwise the byte and its flag are held unchanged.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    text_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (text_pending.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        nxt = text_pending.pop_front();
        in_valid <= 1'b1;
        in_byte  <= nxt.b;
        in_final <= nxt.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. Once in the run, it refuses results for a long stretch while
  // the driver keeps offering bytes, so that the job queue inside the block
  // fills and the block has to stall its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : unit_receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken_cnt >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Both handshakes are sampled at the same edge, and the result is
  // checked before the accepted byte is fed to the model, so the outcome
  // never depends on the order in which processes run at that edge. A result
  // can never belong to a byte taken at the same edge, given the pipeline.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : unit_monitor
    utf16_unit_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (units_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("tb: unexpected code unit %h run_end %b text_end %b",
                     code_unit, run_end, text_end);
        end else begin
          want = units_due.pop_front();
          if (code_unit !== want.unit || run_end !== want.run_end ||
              text_end !== want.text_end) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("tb: mismatch: expected unit %h run_end %b text_end %b, got %h %b %b",
                       want.unit, want.run_end, want.text_end,
                       code_unit, run_end, text_end);
          end
        end
      end
      if (in_valid && in_ready) begin
        transcode_byte(in_byte, in_final);
        bytes_taken_cnt <= bytes_taken_cnt + 1;
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run. The whole byte stream is built at time zero,
  // before the first clock edge, and then the run is watched to its end.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]  seq[$];
    int unsigned pick;
    int unsigned cut;
    logic        fin;

    // Directed part: field extremes, every length, the narrowed second-byte
    // ranges, invalid leads, broken and truncated sequences.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'hC2, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'hE0, 1'b0); queue_byte(8'hA0, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'hF4, 1'b0); queue_byte(8'h8F, 1'b0);
    queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b0);
    // Invalid leads each give a single replacement.
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hF5, 1'b0);
    // Overlong, surrogate and out-of-range second bytes break the sequence.
    queue_byte(8'hE0, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'hED, 1'b0); queue_byte(8'hA0, 1'b0);
    queue_byte(8'hF4, 1'b0); queue_byte(8'h90, 1'b0);
    // A buffered continuation gives its own replacement; the ASCII byte that
    // breaks the sequence is decoded afresh.
    queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'h41, 1'b0);
    // A lead held at string end.
    queue_byte(8'hC3, 1'b1);
    // Broken by a new lead that is itself flushed at string end: four units.
    queue_byte(8'hF0, 1'b0); queue_byte(8'h90, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'hE2, 1'b1);

    // Random part: mostly well-formed text, mixed with broken sequences and noise.
    cut = text_pending.size() + RANDOM_BYTES;
    while (text_pending.size() < cut) begin
      pick = $urandom_range(99, 0);
      if (pick < 65) begin
        build_sequence(seq);
        fin = ($urandom_range(7, 0) == 0);
        foreach (seq[i]) queue_byte(seq[i], fin && (i == seq.size() - 1));
      end else if (pick < 85) begin
        do build_sequence(seq); while (seq.size() < 2);
        seq = seq[0 : $urandom_range(seq.size() - 2, 0)];
        if ($urandom_range(2, 0) == 0) begin
          // Cut short by the end of the string.
          foreach (seq[i]) queue_byte(seq[i], i == seq.size() - 1);
        end else begin
          foreach (seq[i]) queue_byte(seq[i], 1'b0);
          if (seq.size() == 1 && $urandom_range(1, 0) == 1)
            queue_byte(bad_second(seq[0]), $urandom_range(9, 0) == 0);
          else
            queue_byte(8'($urandom_range(255, 0)), $urandom_range(9, 0) == 0);
        end
      end else begin
        queue_byte(8'($urandom_range(255, 0)), $urandom_range(9, 0) == 0);
      end
    end

    // Reset is asserted once, at the start of the run.
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Checks run on the falling edge, away from the driving edge.
    do @(negedge clk); while (text_pending.size() != 0 || in_valid);
    do @(negedge clk); while (units_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_cnt == 0 && units_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
